// ===== design/fsp_pkg.sv =====
// Shared codes, character constants and decode functions for the format specifier parser.
package fsp_pkg;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_LITERAL = 2'd1,
        ST_ERROR   = 2'd2
    } t_status;

    localparam logic [1:0] LEN_NONE = 2'd0;
    localparam logic [1:0] LEN_H    = 2'd1;
    localparam logic [1:0] LEN_L    = 2'd2;
    localparam logic [1:0] LEN_BIG_L = 2'd3;

    localparam logic [3:0] SPEC_C    = 4'd0;
    localparam logic [3:0] SPEC_D    = 4'd1;
    localparam logic [3:0] SPEC_I    = 4'd2;
    localparam logic [3:0] SPEC_E    = 4'd3;
    localparam logic [3:0] SPEC_F    = 4'd4;
    localparam logic [3:0] SPEC_BIG_E = 4'd5;
    localparam logic [3:0] SPEC_G    = 4'd6;
    localparam logic [3:0] SPEC_BIG_G = 4'd7;
    localparam logic [3:0] SPEC_O    = 4'd8;
    localparam logic [3:0] SPEC_S    = 4'd9;
    localparam logic [3:0] SPEC_U    = 4'd10;
    localparam logic [3:0] SPEC_X    = 4'd11;
    localparam logic [3:0] SPEC_BIG_X = 4'd12;
    localparam logic [3:0] SPEC_P    = 4'd13;
    localparam logic [3:0] SPEC_N    = 4'd14;
    localparam logic [3:0] SPEC_NONE = 4'd15;

    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_DIGIT_LO = 8'd48;
    localparam logic [7:0] CH_DIGIT_HI = 8'd57;
    localparam logic [7:0] CH_PERCENT  = 8'h25;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_HASH     = 8'h23;
    localparam logic [7:0] CH_ZERO     = 8'h30;

    // Flag bit order: plus, minus, space, alternate form, zero padding.
    function automatic logic [4:0] flag_mask(input logic [7:0] ch);
        logic [4:0] m;
        case (ch)
            CH_PLUS:  m = 5'b00001;
            CH_MINUS: m = 5'b00010;
            CH_SPACE: m = 5'b00100;
            CH_HASH:  m = 5'b01000;
            CH_ZERO:  m = 5'b10000;
            default:  m = 5'b00000;
        endcase
        return m;
    endfunction

    function automatic logic [1:0] len_index(input logic [7:0] ch);
        logic [1:0] l;
        case (ch)
            8'h68:   l = LEN_H;
            8'h6C:   l = LEN_L;
            8'h4C:   l = LEN_BIG_L;
            default: l = LEN_NONE;
        endcase
        return l;
    endfunction

    function automatic logic [3:0] spec_index(input logic [7:0] ch);
        logic [3:0] s;
        case (ch)
            8'h63:   s = SPEC_C;
            8'h64:   s = SPEC_D;
            8'h69:   s = SPEC_I;
            8'h65:   s = SPEC_E;
            8'h66:   s = SPEC_F;
            8'h45:   s = SPEC_BIG_E;
            8'h67:   s = SPEC_G;
            8'h47:   s = SPEC_BIG_G;
            8'h6F:   s = SPEC_O;
            8'h73:   s = SPEC_S;
            8'h75:   s = SPEC_U;
            8'h78:   s = SPEC_X;
            8'h58:   s = SPEC_BIG_X;
            8'h70:   s = SPEC_P;
            8'h6E:   s = SPEC_N;
            default: s = SPEC_NONE;
        endcase
        return s;
    endfunction

endpackage

// ===== design/fsp_digit_acc.sv =====
// Decimal digit accumulator: acc * 10 + digit, saturating, with "not given" and star read as 0.
module fsp_digit_acc #(
    parameter int NUM_BITS = 16
) (
    input  logic signed [NUM_BITS:0] i_acc,
    input  logic        [3:0]        i_digit,
    output logic signed [NUM_BITS:0] o_acc
);

    logic [NUM_BITS-1:0] base;
    logic [NUM_BITS+3:0] prod;
    logic                sat;

    always_comb begin
        base = i_acc[NUM_BITS] ? '0 : i_acc[NUM_BITS-1:0];
        prod = {1'b0, base, 3'b000} + {3'b000, base, 1'b0} + {{NUM_BITS{1'b0}}, i_digit};
        sat  = |prod[NUM_BITS+3:NUM_BITS];
        o_acc = sat ? {1'b0, {NUM_BITS{1'b1}}} : {1'b0, prod[NUM_BITS-1:0]};
    end

endmodule

// ===== design/format_spec_parser_core.sv =====
// Format specifier parser: one character per beat, one result beat per finished specification.
//
// Input channel (i_in_valid / o_in_ready) carries one character of the format string and
// a start mark that is set on the first character after a percent sign. Output channel
// (o_out_valid / i_out_ready) carries one result beat when a specification completes,
// when the first character is a literal percent, or when a parse error is found.
// Characters with no start mark outside a specification are dropped silently.
//
// A character is taken into an input register, decoded against the parse state, and the
// result is written into the output register; the decode itself is combinational. One
// character is taken every cycle while the receiver does not stall, limited only by the
// single decode stage between the two registers.
// While the receiver stalls with a result pending, the character in the input register
// waits and o_in_ready drops once that register is full; nothing is lost.
//
// Reset clears both registers' valid bits and returns the parser to idle with
// width and precision "not given".
module format_spec_parser_core #(
    parameter int NUM_BITS   = 16,
    parameter int COUNT_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [7:0]              i_ch,
    input  logic                    i_start_req,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [1:0]              o_status,
    output logic                    o_flag_sign,
    output logic                    o_flag_left,
    output logic                    o_flag_space,
    output logic                    o_flag_alt,
    output logic                    o_flag_pad_zero,
    output logic signed [NUM_BITS:0] o_field_width,
    output logic signed [NUM_BITS:0] o_field_precision,
    output logic [1:0]              o_length_code,
    output logic [3:0]              o_spec_code,
    output logic                    o_is_signed,
    output logic [COUNT_BITS-1:0]   o_consumed
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_FLAGS = 3'd1,
        PH_WDIG  = 3'd2,
        PH_WSTAR = 3'd3,
        PH_PREC  = 3'd4,
        PH_PDIG  = 3'd5,
        PH_PSTAR = 3'd6,
        PH_LEN   = 3'd7
    } t_phase;

    localparam logic signed [NUM_BITS:0] ACC_NONE = '1;
    localparam logic signed [NUM_BITS:0] ACC_STAR = {{NUM_BITS{1'b1}}, 1'b0};

    // Input register
    logic       r_in_valid;
    logic [7:0] r_ch;
    logic       r_start;

    // Parse state
    t_phase                   r_phase,  n_phase;
    logic [4:0]               r_flags,  n_flags;
    logic signed [NUM_BITS:0] r_width,  n_width;
    logic signed [NUM_BITS:0] r_prec,   n_prec;
    logic [1:0]               r_len,    n_len;
    logic [COUNT_BITS-1:0]    r_count,  n_count;

    // Output register
    logic                     r_out_valid;
    logic [1:0]               r_status;
    logic [4:0]               r_oflags;
    logic signed [NUM_BITS:0] r_owidth;
    logic signed [NUM_BITS:0] r_oprec;
    logic [1:0]               r_olen;
    logic [3:0]               r_ospec;
    logic [COUNT_BITS-1:0]    r_ocount;

    // State as seen by the character in the input register (start mark applied)
    t_phase                   e_phase;
    logic [4:0]               e_flags;
    logic signed [NUM_BITS:0] e_width;
    logic signed [NUM_BITS:0] e_prec;
    logic [1:0]               e_len;
    logic [COUNT_BITS-1:0]    e_count;
    logic [COUNT_BITS-1:0]    count_inc;

    logic                     proc;
    logic                     emit;
    fsp_pkg::t_status         res_status;
    logic [3:0]               res_spec;
    logic                     is_digit;
    logic [4:0]               fbit;
    logic [1:0]               ln;
    logic [3:0]               sp;
    logic                     prec_side;
    logic signed [NUM_BITS:0] acc_in;
    logic signed [NUM_BITS:0] acc_out;

    assign proc       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || proc;

    assign e_phase = r_start ? PH_FLAGS : r_phase;
    assign e_flags = r_start ? '0 : r_flags;
    assign e_width = r_start ? ACC_NONE : r_width;
    assign e_prec  = r_start ? ACC_NONE : r_prec;
    assign e_len   = r_start ? fsp_pkg::LEN_NONE : r_len;
    assign e_count = r_start ? '0 : r_count;

    assign count_inc = (&e_count) ? e_count : e_count + 1'b1;

    assign is_digit  = (r_ch >= fsp_pkg::CH_DIGIT_LO) && (r_ch <= fsp_pkg::CH_DIGIT_HI);
    assign fbit      = fsp_pkg::flag_mask(r_ch);
    assign ln        = fsp_pkg::len_index(r_ch);
    assign sp        = fsp_pkg::spec_index(r_ch);
    assign prec_side = (e_phase == PH_PREC) || (e_phase == PH_PDIG);
    assign acc_in    = prec_side ? e_prec : e_width;

    fsp_digit_acc #(
        .NUM_BITS (NUM_BITS)
    ) u_digit_acc (
        .i_acc   (acc_in),
        .i_digit (r_ch[3:0]),
        .o_acc   (acc_out)
    );

    always_comb begin
        n_phase    = e_phase;
        n_flags    = e_flags;
        n_width    = e_width;
        n_prec     = e_prec;
        n_len      = e_len;
        n_count    = e_count;
        emit       = 1'b0;
        res_status = fsp_pkg::ST_DONE;
        res_spec   = fsp_pkg::SPEC_NONE;

        if (e_phase == PH_IDLE) begin
            n_phase = PH_IDLE;
        end else if (e_phase == PH_FLAGS && e_count == '0 && r_ch == fsp_pkg::CH_PERCENT) begin
            emit       = 1'b1;
            res_status = fsp_pkg::ST_LITERAL;
        end else if (e_phase == PH_FLAGS && fbit != '0) begin
            n_flags = e_flags | fbit;
            n_count = count_inc;
        end else if (is_digit && (e_phase == PH_FLAGS || e_phase == PH_WDIG)) begin
            n_width = acc_out;
            n_phase = PH_WDIG;
            n_count = count_inc;
        end else if (is_digit && prec_side) begin
            n_prec  = acc_out;
            n_phase = PH_PDIG;
            n_count = count_inc;
        end else if (r_ch == fsp_pkg::CH_STAR && e_phase == PH_FLAGS) begin
            n_width = ACC_STAR;
            n_phase = PH_WSTAR;
            n_count = count_inc;
        end else if (r_ch == fsp_pkg::CH_STAR && e_phase == PH_PREC) begin
            n_prec  = ACC_STAR;
            n_phase = PH_PSTAR;
            n_count = count_inc;
        end else if (r_ch == fsp_pkg::CH_DOT &&
                     (e_phase == PH_FLAGS || e_phase == PH_WDIG || e_phase == PH_WSTAR)) begin
            n_prec  = '0;
            n_phase = PH_PREC;
            n_count = count_inc;
        end else if (ln != fsp_pkg::LEN_NONE && e_phase != PH_LEN) begin
            n_len   = ln;
            n_phase = PH_LEN;
            n_count = count_inc;
        end else if (sp != fsp_pkg::SPEC_NONE) begin
            n_count  = count_inc;
            emit     = 1'b1;
            res_spec = sp;
        end else begin
            emit       = 1'b1;
            res_status = fsp_pkg::ST_ERROR;
        end

        if (emit) begin
            n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_flags     <= '0;
            r_width     <= ACC_NONE;
            r_prec      <= ACC_NONE;
            r_len       <= fsp_pkg::LEN_NONE;
            r_count     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (proc) begin
                r_phase <= n_phase;
                r_flags <= n_flags;
                r_width <= n_width;
                r_prec  <= n_prec;
                r_len   <= n_len;
                r_count <= n_count;
            end
            if (proc && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (i_in_valid && o_in_ready) begin
            r_ch    <= i_ch;
            r_start <= i_start_req;
        end
        if (proc && emit) begin
            r_status <= res_status;
            r_oflags <= n_flags;
            r_owidth <= n_width;
            r_oprec  <= n_prec;
            r_olen   <= n_len;
            r_ospec  <= res_spec;
            r_ocount <= n_count;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_flag_sign       = r_oflags[0];
    assign o_flag_left       = r_oflags[1];
    assign o_flag_space      = r_oflags[2];
    assign o_flag_alt        = r_oflags[3];
    assign o_flag_pad_zero   = r_oflags[4];
    assign o_field_width     = r_owidth;
    assign o_field_precision = r_oprec;
    assign o_length_code     = r_olen;
    assign o_spec_code       = r_ospec;
    assign o_is_signed       = (r_ospec >= fsp_pkg::SPEC_D) && (r_ospec <= fsp_pkg::SPEC_BIG_G);
    assign o_consumed        = r_ocount;

    // A completed specification always names a conversion, the other results never do.
    a_spec_matches_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_status == fsp_pkg::ST_DONE) == (o_spec_code != fsp_pkg::SPEC_NONE)))
        else $error("spec code does not agree with status");

    // A literal percent consumes nothing and carries the cleared fields.
    a_literal_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == fsp_pkg::ST_LITERAL) |->
            (o_consumed == '0 && o_field_width == ACC_NONE && o_field_precision == ACC_NONE))
        else $error("literal percent result carries parse data");

    // After any result the parser is idle until the next start mark.
    a_idle_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && emit) |=> (r_phase == PH_IDLE))
        else $error("parser not idle after a result");

    // A result beat is only produced into a free or draining output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> ($stable(r_ocount) && $stable(r_ospec)))
        else $error("pending result overwritten");

endmodule

// ===== dv/format_spec_parser_core_tb.sv =====
// Self-checking testbench for the format specifier parser core.
`timescale 1ns / 100ps

module format_spec_parser_core_tb;

    localparam int NUM_BITS    = 16;
    localparam int COUNT_BITS  = 8;
    localparam int NUM_SAT     = (1 << NUM_BITS) - 1;
    localparam int COUNT_SAT   = (1 << COUNT_BITS) - 1;
    localparam int TARGET_CHARS = 1850;
    localparam int STALL_LIMIT = 1000;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_FLAGS,
        SCAN_WIDTH,
        SCAN_WSTAR,
        SCAN_DOT,
        SCAN_PREC,
        SCAN_PSTAR,
        SCAN_LENGTH
    } t_scan_phase;

    typedef struct {
        fsp_pkg::t_status        status;
        logic [4:0]              flags;
        logic signed [NUM_BITS:0] width;
        logic signed [NUM_BITS:0] prec;
        logic [1:0]              len;
        logic [3:0]              spec;
        logic                    is_signed;
        logic [COUNT_BITS-1:0]   consumed;
    } t_spec_fields;

    class fmt_spec_scoreboard;
        t_scan_phase  phase;
        logic [4:0]   flags;
        int           width_acc;
        int           prec_acc;
        logic [1:0]   len_sel;
        int           char_cnt;
        t_spec_fields expected_specs[$];
        int           errors;
        string        letters;

        function new();
            letters = "cdiefEgGosuxXpn";
            errors  = 0;
            phase   = SCAN_IDLE;
            clear_spec();
        endfunction

        function void clear_spec();
            flags     = '0;
            width_acc = -1;
            prec_acc  = -1;
            len_sel   = fsp_pkg::LEN_NONE;
            char_cnt  = 0;
        endfunction

        function int pending();
            return expected_specs.size();
        endfunction

        function void count_char();
            if (char_cnt < COUNT_SAT) begin
                char_cnt++;
            end
        endfunction

        function int add_digit(int acc, int d);
            int v;
            v = (acc < 0 ? 0 : acc) * 10 + d;
            return (v > NUM_SAT) ? NUM_SAT : v;
        endfunction

        function void post(fsp_pkg::t_status st, logic [3:0] spec);
            t_spec_fields r;
            r.status    = st;
            r.flags     = flags;
            r.width     = width_acc[NUM_BITS:0];
            r.prec      = prec_acc[NUM_BITS:0];
            r.len       = len_sel;
            r.spec      = spec;
            r.is_signed = (spec >= fsp_pkg::SPEC_D && spec <= fsp_pkg::SPEC_BIG_G);
            r.consumed  = char_cnt[COUNT_BITS-1:0];
            expected_specs.push_back(r);
            phase = SCAN_IDLE;
        endfunction

        // Advances the parse by one accepted input beat.
        function void note_char(logic [7:0] c, logic start);
            logic [4:0] fbit;
            logic [3:0] spec;
            logic [1:0] len;
            logic       digit;
            digit = (c >= fsp_pkg::CH_DIGIT_LO && c <= fsp_pkg::CH_DIGIT_HI);
            if (start) begin
                clear_spec();
                phase = SCAN_FLAGS;
            end
            if (phase == SCAN_IDLE) begin
                return;
            end
            if (phase == SCAN_FLAGS) begin
                if (char_cnt == 0 && c == fsp_pkg::CH_PERCENT) begin
                    post(fsp_pkg::ST_LITERAL, fsp_pkg::SPEC_NONE);
                    return;
                end
                case (c)
                    fsp_pkg::CH_PLUS:  fbit = 5'b00001;
                    fsp_pkg::CH_MINUS: fbit = 5'b00010;
                    fsp_pkg::CH_SPACE: fbit = 5'b00100;
                    fsp_pkg::CH_HASH:  fbit = 5'b01000;
                    fsp_pkg::CH_ZERO:  fbit = 5'b10000;
                    default:           fbit = 5'b00000;
                endcase
                if (fbit != 0) begin
                    flags |= fbit;
                    count_char();
                    return;
                end
            end
            spec = fsp_pkg::SPEC_NONE;
            for (int i = 0; i < 15; i++) begin
                if (c == letters[i]) begin
                    spec = i[3:0];
                    break;
                end
            end
            case (c)
                "h":     len = fsp_pkg::LEN_H;
                "l":     len = fsp_pkg::LEN_L;
                "L":     len = fsp_pkg::LEN_BIG_L;
                default: len = fsp_pkg::LEN_NONE;
            endcase
            if (digit && (phase == SCAN_FLAGS || phase == SCAN_WIDTH)) begin
                width_acc = add_digit(width_acc, c - fsp_pkg::CH_DIGIT_LO);
                phase = SCAN_WIDTH;
                count_char();
            end else if (digit && (phase == SCAN_DOT || phase == SCAN_PREC)) begin
                prec_acc = add_digit(prec_acc, c - fsp_pkg::CH_DIGIT_LO);
                phase = SCAN_PREC;
                count_char();
            end else if (c == fsp_pkg::CH_STAR && phase == SCAN_FLAGS) begin
                width_acc = -2;
                phase = SCAN_WSTAR;
                count_char();
            end else if (c == fsp_pkg::CH_STAR && phase == SCAN_DOT) begin
                prec_acc = -2;
                phase = SCAN_PSTAR;
                count_char();
            end else if (c == fsp_pkg::CH_DOT && (phase == SCAN_FLAGS || phase == SCAN_WIDTH ||
                                                  phase == SCAN_WSTAR)) begin
                prec_acc = 0;
                phase = SCAN_DOT;
                count_char();
            end else if (len != fsp_pkg::LEN_NONE && phase != SCAN_LENGTH) begin
                len_sel = len;
                phase = SCAN_LENGTH;
                count_char();
            end else if (spec != fsp_pkg::SPEC_NONE) begin
                count_char();
                post(fsp_pkg::ST_DONE, spec);
            end else begin
                post(fsp_pkg::ST_ERROR, fsp_pkg::SPEC_NONE);
            end
        endfunction

        function void match(string field, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [1:0] status, logic [4:0] fl,
                                   logic signed [NUM_BITS:0] w, logic signed [NUM_BITS:0] p,
                                   logic [1:0] len, logic [3:0] spec, logic sgn,
                                   logic [COUNT_BITS-1:0] cnt);
            t_spec_fields r;
            if (expected_specs.size() == 0) begin
                $error("result beat arrived with no specification outstanding");
                errors++;
                return;
            end
            r = expected_specs.pop_front();
            match("status", int'(r.status), int'(status));
            match("flag_sign", r.flags[0], fl[0]);
            match("flag_left", r.flags[1], fl[1]);
            match("flag_space", r.flags[2], fl[2]);
            match("flag_alt", r.flags[3], fl[3]);
            match("flag_pad_zero", r.flags[4], fl[4]);
            match("field_width", int'(r.width), int'(w));
            match("field_precision", int'(r.prec), int'(p));
            match("length_code", r.len, len);
            match("spec_code", r.spec, spec);
            match("is_signed", r.is_signed, sgn);
            match("consumed", r.consumed, cnt);
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [7:0]               i_ch = 8'h00;
    logic                     i_start_req = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic [1:0]               o_status;
    logic                     o_flag_sign;
    logic                     o_flag_left;
    logic                     o_flag_space;
    logic                     o_flag_alt;
    logic                     o_flag_pad_zero;
    logic signed [NUM_BITS:0] o_field_width;
    logic signed [NUM_BITS:0] o_field_precision;
    logic [1:0]               o_length_code;
    logic [3:0]               o_spec_code;
    logic                     o_is_signed;
    logic [COUNT_BITS-1:0]    o_consumed;

    fmt_spec_scoreboard sb = new();
    bit steady = 1'b0;
    int chars_sent = 0;
    int stall_cycles = 0;

    format_spec_parser_core #(
        .NUM_BITS(NUM_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_ch(i_ch),
        .i_start_req(i_start_req),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_status(o_status),
        .o_flag_sign(o_flag_sign),
        .o_flag_left(o_flag_left),
        .o_flag_space(o_flag_space),
        .o_flag_alt(o_flag_alt),
        .o_flag_pad_zero(o_flag_pad_zero),
        .o_field_width(o_field_width),
        .o_field_precision(o_field_precision),
        .o_length_code(o_length_code),
        .o_spec_code(o_spec_code),
        .o_is_signed(o_is_signed),
        .o_consumed(o_consumed)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one; none at all in steady stretches.
    function automatic int pick_gap();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sb.note_char(i_ch, i_start_req);
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_status, {o_flag_pad_zero, o_flag_alt, o_flag_space,
                                o_flag_left, o_flag_sign}, o_field_width,
                                o_field_precision, o_length_code, o_spec_code,
                                o_is_signed, o_consumed);
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        int n;
        forever begin
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            n = pick_gap();
            if (n > 0) begin
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    task automatic send_char(input logic [7:0] c, input logic start);
        int n;
        n = pick_gap();
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_ch        <= c;
        i_start_req <= start;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Sends the first stop_at characters of a specification; the character at
    // bad_pos is swapped for a random byte.
    task automatic send_text(input string s, input int bad_pos, input int stop_at);
        logic [7:0] c;
        for (int i = 0; i < stop_at; i++) begin
            c = (i == bad_pos) ? 8'($urandom_range(0, 255)) : s[i];
            send_char(c, i == 0);
            chars_sent++;
        end
    endtask

    // Raw bytes with a start mark on the first and now and then on a later one.
    task automatic send_random_burst();
        int len;
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
            send_char(8'($urandom_range(0, 255)), (i == 0) || ($urandom_range(0, 7) == 0));
            chars_sent++;
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic string build_spec();
        string s;
        string flag_chars;
        string len_chars;
        int k;
        flag_chars = "+- #0";
        len_chars  = "hlL";
        s = "";
        repeat ($urandom_range(0, 3)) begin
            k = $urandom_range(0, 4);
            s = {s, flag_chars.substr(k, k)};
        end
        case ($urandom_range(0, 9))
            4, 5, 6, 7: s = {s, $sformatf("%0d", $urandom_range(1, 300))};
            8:          s = {s, "*"};
            9:          s = {s, $sformatf("%0d", $urandom_range(1, 9999999))};
            default: ;
        endcase
        case ($urandom_range(0, 9))
            5:    s = {s, "."};
            6, 7: s = {s, ".", $sformatf("%0d", $urandom_range(0, 300))};
            8:    s = {s, ".*"};
            9:    s = {s, ".", $sformatf("%0d", $urandom_range(0, 9999999))};
            default: ;
        endcase
        if ($urandom_range(0, 9) > 5) begin
            k = $urandom_range(0, 2);
            s = {s, len_chars.substr(k, k)};
        end
        k = $urandom_range(0, 14);
        s = {s, sb.letters.substr(k, k)};
        return s;
    endfunction

    initial begin
        string s;
        int r;
        bit long_done;
        long_done = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: ignored byte before any start, literal percent, all flags with
        // star width and precision, saturating digits, NUL, bare dot, restart mid-parse.
        send_char(8'hFF, 1'b0);
        send_text("%", -1, 1);
        s = "+-# 0*.*Lf";
        send_text(s, -1, s.len());
        s = "99999.9lx";
        send_text(s, -1, s.len());
        send_char(8'h00, 1'b1);
        chars_sent++;
        send_text(".u", -1, 2);
        send_text("7", -1, 1);
        send_text("c", -1, 1);
        drain_results();

        while (chars_sent < TARGET_CHARS) begin
            if ($urandom_range(0, 149) == 0) begin
                steady = ~steady;
            end
            if (chars_sent > 900 && chars_sent < 960) begin
                drain_results();
            end
            r = $urandom_range(0, 99);
            if (!long_done && chars_sent > 600) begin
                // Enough flags to push the consumed count into saturation.
                s = "";
                repeat (260) s = {s, "+"};
                s = {s, "-5.3hd"};
                send_text(s, -1, s.len());
                long_done = 1'b1;
            end else if (r < 70) begin
                s = build_spec();
                send_text(s, -1, s.len());
            end else if (r < 78) begin
                send_text("%", -1, 1);
            end else if (r < 90) begin
                s = build_spec();
                if ($urandom_range(0, 1) == 0) begin
                    send_text(s, $urandom_range(0, s.len() - 1), s.len());
                end else begin
                    send_text(s, -1, $urandom_range(1, s.len()));
                end
            end else if (r < 95) begin
                repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)), 1'b0);
            end else begin
                send_random_burst();
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
